// ----- hdl/sibs_pkg.sv -----
// Shared types and constants for the signed integer to radix text converter.
package sibs_pkg;

    // Character and digit widths
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int RADIX_W = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;

    // Sign character
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    // Restoring divide steps done per clock
    localparam int STEPS_PER_CYCLE = 8;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture magnitude and sign of a new number
        logic div_step;    // run STEPS_PER_CYCLE restoring steps of the divide
        logic push;        // push finished digit, clear remainder
        logic load_sign;   // output register takes the minus character
        logic load_digit;  // output register takes top digit, stack pops
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic quot_zero;   // quotient of this divide pass is zero
        logic neg;         // number being converted is negative
        logic last_digit;  // one digit left on the stack
    } dp_sts_t;

endpackage

// ----- hdl/sibs_dp.sv -----
// Datapath: configuration registers, iterative divider, digit stack, output register.
module sibs_dp #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32,
    parameter int DIV_W      = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sibs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sibs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [VALUE_BITS-1:0]          number,
    input  sibs_pkg::ctl_cmd_t             cmd,
    output sibs_pkg::dp_sts_t              sts,
    output logic [sibs_pkg::CHAR_W-1:0]     out_char,
    output logic                           out_last
);

    localparam int STACK_W = VALUE_BITS * sibs_pkg::DIGIT_W;
    localparam int CNT_W   = $clog2(VALUE_BITS + 1);
    localparam logic [sibs_pkg::RADIX_W-1:0] RADIX_MAX = sibs_pkg::RADIX_W'(MAX_RADIX);

    logic [sibs_pkg::RADIX_W-1:0]    radix_reg;
    logic [sibs_pkg::CFG_DATA_W-1:0] alpha_low_reg;
    logic [sibs_pkg::CFG_DATA_W-1:0] alpha_high_reg;
    logic [sibs_pkg::RADIX_W-1:0]    eff_radix;

    logic [DIV_W-1:0]                mag_reg, mag_next;
    logic [sibs_pkg::RADIX_W-1:0]    rem_reg, rem_next;
    logic                            neg_reg;
    logic [STACK_W-1:0]              stack_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [sibs_pkg::CHAR_W-1:0]     char_reg;
    logic                            last_reg;

    logic [VALUE_BITS-1:0]           abs_val;
    logic [sibs_pkg::DIGIT_W-1:0]    top_digit;
    logic [2*sibs_pkg::CFG_DATA_W-1:0] alphabet;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= sibs_pkg::RADIX_RESET;
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sibs_pkg::REG_RADIX:      radix_reg      <= cfg_data[sibs_pkg::RADIX_W-1:0];
                sibs_pkg::REG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                sibs_pkg::REG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate radix into the supported range
    always_comb
    begin
        if (radix_reg < sibs_pkg::RADIX_MIN)
            eff_radix = sibs_pkg::RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            eff_radix = RADIX_MAX;
        else
            eff_radix = radix_reg;
    end

    // Magnitude as unsigned; most negative value wraps to 2^(N-1) correctly
    assign abs_val = number[VALUE_BITS-1] ? (~number + VALUE_BITS'(1)) : number;

    // Restoring divide, several bit steps per cycle, quotient shifts into mag
    always_comb
    begin
        logic [DIV_W-1:0]             m;
        logic [sibs_pkg::RADIX_W-1:0] r;
        logic [sibs_pkg::RADIX_W-1:0] t;
        m = mag_reg;
        r = rem_reg;
        for (int i = 0; i < sibs_pkg::STEPS_PER_CYCLE; i++)
        begin
            t = {r[sibs_pkg::DIGIT_W-1:0], m[DIV_W-1]};
            m = {m[DIV_W-2:0], 1'b0};
            if (t >= eff_radix)
            begin
                r    = t - eff_radix;
                m[0] = 1'b1;
            end
            else
            begin
                r = t;
            end
        end
        mag_next = m;
        rem_next = r;
    end

    // Divider registers and digit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rem_reg <= '0;
                cnt_reg <= '0;
                neg_reg <= number[VALUE_BITS-1];
            end
            else if (cmd.div_step)
            begin
                rem_reg <= cmd.push ? '0 : rem_next;
                if (cmd.push)
                    cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.load_digit)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Magnitude, digit stack (top in the low bits) and output payload
    assign top_digit = stack_reg[sibs_pkg::DIGIT_W-1:0];
    assign alphabet  = {alpha_high_reg, alpha_low_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mag_reg <= DIV_W'(abs_val);
        else if (cmd.div_step)
            mag_reg <= mag_next;

        if (cmd.div_step && cmd.push)
            stack_reg <= {stack_reg[STACK_W-sibs_pkg::DIGIT_W-1:0],
                          rem_next[sibs_pkg::DIGIT_W-1:0]};
        else if (cmd.load_digit)
            stack_reg <= {{sibs_pkg::DIGIT_W{1'b0}},
                          stack_reg[STACK_W-1:sibs_pkg::DIGIT_W]};

        if (cmd.load_sign)
        begin
            char_reg <= sibs_pkg::MINUS_CHAR;
            last_reg <= 1'b0;
        end
        else if (cmd.load_digit)
        begin
            char_reg <= alphabet[{top_digit, 3'b000} +: sibs_pkg::CHAR_W];
            last_reg <= (cnt_reg == CNT_W'(1));
        end
    end

    assign sts.quot_zero  = (mag_next == '0);
    assign sts.neg        = neg_reg;
    assign sts.last_digit = (cnt_reg == CNT_W'(1));

    assign out_char = char_reg;
    assign out_last = last_reg;

    // Remainder always below the radix
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < eff_radix)
        else $error("remainder reached radix");

    // Stack never overflows on a push
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && cmd.push) |-> (cnt_reg < CNT_W'(VALUE_BITS)))
        else $error("digit stack overflow");

    // Never pop an empty stack
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_digit |-> (cnt_reg != '0))
        else $error("digit stack underflow");

endmodule

// ----- hdl/sibs_ctrl.sv -----
// Controller: sequences load, per-digit divide passes, sign and digit emission.
module sibs_ctrl #(
    parameter int DIV_CYCLES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  sibs_pkg::dp_sts_t  sts,
    output sibs_pkg::ctl_cmd_t cmd
);

    localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             pass_done;

    assign out_free  = !out_valid_reg || out_ready;
    assign pass_done = (step_reg == CNT_W'(DIV_CYCLES - 1));

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (pass_done)
                begin
                    cmd.push  = 1'b1;
                    step_next = '0;
                    if (sts.quot_zero)
                        state_next = sts.neg ? ST_SIGN : ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    cmd.load_sign  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_digit = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.last_digit)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // A divide pass always runs its full length before the digit is pushed
    a_pass_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> pass_done && (state_reg == ST_DIV))
        else $error("digit pushed before divide pass finished");

    // Output register is only reloaded once its beat has been taken
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_sign || cmd.load_digit) |-> (!out_valid_reg || out_ready))
        else $error("output beat overwritten");

    // A load starts a divide pass from its first step
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DIV) && (step_reg == '0))
        else $error("load did not start a divide pass");

endmodule

// ----- hdl/signed_int_to_base_string.sv -----
// Top level of the signed integer to radix text converter.
//
// Converts one signed VALUE_BITS-bit number per input beat into its text in
// the configured radix, most significant character first, one character per
// output beat with tlast on the final one; negatives start with '-'. Digits
// are produced least significant first by a shared restoring divider that
// does 8 quotient bits per clock, and are held on a digit stack. One number
// is worked on at a time; the last character can still wait in the output
// register while the next number is taken. Configuration must be written
// only while idle, by the user; the block itself does not enforce it.
module signed_int_to_base_string #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]        s_axis_tdata,  // [VALUE_BITS-1:0] number
    // Output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [sibs_pkg::CHAR_W-1:0]             m_axis_tdata,  // [7:0] out_char
    output logic                                   m_axis_tlast,  // last_char
    // Configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sibs_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [sibs_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int DIV_W      = ((VALUE_BITS + 7) / 8) * 8;
    localparam int DIV_CYCLES = DIV_W / sibs_pkg::STEPS_PER_CYCLE;

    sibs_pkg::ctl_cmd_t cmd;
    sibs_pkg::dp_sts_t  sts;

    // Registers always take a write beat
    assign cfg_ready = 1'b1;

    sibs_ctrl #(
        .DIV_CYCLES (DIV_CYCLES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sibs_dp #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS),
        .DIV_W      (DIV_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .number    (s_axis_tdata[VALUE_BITS-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
